@@ rtl/bqv_pkg.sv @@
// ----------------------------------------------------------------------------
// bqv_pkg
// Shared types, character codes and decode functions for the bracket and
// quote validator.
// ----------------------------------------------------------------------------
package bqv_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 32;
	localparam int unsigned POS_WIDTH_DEF   = 16;

	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned RKIND_W  = 3;
	localparam int unsigned OUTPOS_W = 16;

	localparam logic [CHAR_W-1:0] CH_LPAREN  = 8'h28; // (
	localparam logic [CHAR_W-1:0] CH_RPAREN  = 8'h29; // )
	localparam logic [CHAR_W-1:0] CH_LBRACK  = 8'h5B; // [
	localparam logic [CHAR_W-1:0] CH_RBRACK  = 8'h5D; // ]
	localparam logic [CHAR_W-1:0] CH_LBRACE  = 8'h7B; // {
	localparam logic [CHAR_W-1:0] CH_RBRACE  = 8'h7D; // }
	localparam logic [CHAR_W-1:0] CH_LANGLE  = 8'h3C; // <
	localparam logic [CHAR_W-1:0] CH_RANGLE  = 8'h3E; // >
	localparam logic [CHAR_W-1:0] CH_BSLASH  = 8'h5C; // backslash
	localparam logic [CHAR_W-1:0] CH_SQUOTE  = 8'h27; // '
	localparam logic [CHAR_W-1:0] CH_DQUOTE  = 8'h22; // "
	localparam logic [CHAR_W-1:0] CH_NONE    = 8'h00;

	typedef logic [KIND_W-1:0] br_kind_t;

	localparam br_kind_t BK_PAREN = 2'd0;
	localparam br_kind_t BK_BRACK = 2'd1;
	localparam br_kind_t BK_BRACE = 2'd2;
	localparam br_kind_t BK_ANGLE = 2'd3;

	typedef enum logic [RKIND_W-1:0] {
		RK_UNMATCHED = 3'd0,
		RK_UNCLOSED  = 3'd1,
		RK_SQUOTE    = 3'd2,
		RK_DQUOTE    = 3'd3,
		RK_OVERFLOW  = 3'd4,
		RK_VERDICT   = 3'd5
	} report_kind_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2
	} stack_op_t;

	typedef enum logic {
		ST_RUN   = 1'b0,
		ST_FLUSH = 1'b1
	} state_t;

	typedef struct packed {
		logic [RKIND_W-1:0]  kind;
		logic [CHAR_W-1:0]   chr;
		logic [OUTPOS_W-1:0] pos;
		logic                ok;
		logic                last;
	} report_t;

	typedef struct packed {
		logic     hit;
		br_kind_t kind;
	} br_dec_t;

	function automatic br_dec_t open_dec(input logic [CHAR_W-1:0] c);
		br_dec_t d;
		d = '{hit: 1'b1, kind: BK_PAREN};
		unique case (c)
			CH_LPAREN: d.kind = BK_PAREN;
			CH_LBRACK: d.kind = BK_BRACK;
			CH_LBRACE: d.kind = BK_BRACE;
			CH_LANGLE: d.kind = BK_ANGLE;
			default:   d.hit  = 1'b0;
		endcase
		return d;
	endfunction

	function automatic br_dec_t close_dec(input logic [CHAR_W-1:0] c);
		br_dec_t d;
		d = '{hit: 1'b1, kind: BK_PAREN};
		unique case (c)
			CH_RPAREN: d.kind = BK_PAREN;
			CH_RBRACK: d.kind = BK_BRACK;
			CH_RBRACE: d.kind = BK_BRACE;
			CH_RANGLE: d.kind = BK_ANGLE;
			default:   d.hit  = 1'b0;
		endcase
		return d;
	endfunction

	function automatic logic [CHAR_W-1:0] open_char(input br_kind_t k);
		logic [CHAR_W-1:0] c;
		unique case (k)
			BK_PAREN: c = CH_LPAREN;
			BK_BRACK: c = CH_LBRACK;
			BK_BRACE: c = CH_LBRACE;
			default:  c = CH_LANGLE;
		endcase
		return c;
	endfunction

endpackage

@@ rtl/bqv_cell.sv @@
// ----------------------------------------------------------------------------
// bqv_cell
// One stack slot: holds a bracket kind and position, shifts in from the
// slot above on push and from the slot below on pop.
// ----------------------------------------------------------------------------
module bqv_cell #(
	parameter int unsigned POS_WIDTH = bqv_pkg::POS_WIDTH_DEF
) (
	input  logic                    clk,
	input  bqv_pkg::stack_op_t      op,
	input  bqv_pkg::br_kind_t       up_kind,
	input  logic [POS_WIDTH-1:0]    up_pos,
	input  bqv_pkg::br_kind_t       dn_kind,
	input  logic [POS_WIDTH-1:0]    dn_pos,
	output bqv_pkg::br_kind_t       kind,
	output logic [POS_WIDTH-1:0]    pos
);
	import bqv_pkg::*;

	br_kind_t             kind_q;
	logic [POS_WIDTH-1:0] pos_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_PUSH: begin
				kind_q <= up_kind;
				pos_q  <= up_pos;
			end
			OP_POP: begin
				kind_q <= dn_kind;
				pos_q  <= dn_pos;
			end
			default: begin
				kind_q <= kind_q;
				pos_q  <= pos_q;
			end
		endcase
	end

	assign kind = kind_q;
	assign pos  = pos_q;

endmodule

@@ rtl/bqv_stack.sv @@
// ----------------------------------------------------------------------------
// bqv_stack
// Bracket stack as a row of shifting cells; cell 0 is the top. Keeps the
// fill count that tells which cells hold live entries.
// ----------------------------------------------------------------------------
module bqv_stack #(
	parameter int unsigned STACK_DEPTH = bqv_pkg::STACK_DEPTH_DEF,
	parameter int unsigned POS_WIDTH   = bqv_pkg::POS_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bqv_pkg::stack_op_t      op,
	input  logic                    clear,
	input  bqv_pkg::br_kind_t       push_kind,
	input  logic [POS_WIDTH-1:0]    push_pos,
	output bqv_pkg::br_kind_t       top_kind,
	output logic [POS_WIDTH-1:0]    top_pos,
	output logic                    empty,
	output logic                    full
);
	import bqv_pkg::*;

	localparam int unsigned DEPTH_W = $clog2(STACK_DEPTH + 1);

	br_kind_t             kind_w [STACK_DEPTH];
	logic [POS_WIDTH-1:0] pos_w  [STACK_DEPTH];
	logic [DEPTH_W-1:0]   depth_q;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		br_kind_t             up_kind, dn_kind;
		logic [POS_WIDTH-1:0] up_pos, dn_pos;

		if (i == 0) begin : g_top
			assign up_kind = push_kind;
			assign up_pos  = push_pos;
		end else begin : g_mid
			assign up_kind = kind_w[i-1];
			assign up_pos  = pos_w[i-1];
		end

		if (i == STACK_DEPTH - 1) begin : g_bot
			assign dn_kind = BK_PAREN;
			assign dn_pos  = '0;
		end else begin : g_inner
			assign dn_kind = kind_w[i+1];
			assign dn_pos  = pos_w[i+1];
		end

		bqv_cell #(
			.POS_WIDTH(POS_WIDTH)
		) u_cell (
			.clk    (clk),
			.op     (op),
			.up_kind(up_kind),
			.up_pos (up_pos),
			.dn_kind(dn_kind),
			.dn_pos (dn_pos),
			.kind   (kind_w[i]),
			.pos    (pos_w[i])
		);
	end

	// Advance the fill count with the cells; clear wins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (clear) begin
			depth_q <= '0;
		end else begin
			case (op)
				OP_PUSH: depth_q <= depth_q + DEPTH_W'(1);
				OP_POP:  depth_q <= depth_q - DEPTH_W'(1);
				default: depth_q <= depth_q;
			endcase
		end
	end

	assign top_kind = kind_w[0];
	assign top_pos  = pos_w[0];
	assign empty    = (depth_q == '0);
	assign full     = (depth_q == DEPTH_W'(STACK_DEPTH));

endmodule

@@ rtl/bracket_quote_validator.sv @@
// ----------------------------------------------------------------------------
// bracket_quote_validator
// Streaming bracket and quote checker over a byte-wide text channel.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid / byte_stall) carries one character per beat
//   with end_of_text on the final character. The report channel
//   (report_valid / report_stall) carries one report per beat; run_last
//   marks the last report caused by one input byte.
//   Throughput is one byte per cycle while the text streams and no report
//   waits on a stalled receiver. A byte that gives an unmatched-closing or
//   overflow report shows it on the report port the cycle after its beat,
//   from an output register. After the end_of_text byte the block walks
//   the stack, one report per open bracket (top first), then one per open
//   quote, then the verdict, during which byte_stall stays high. Each pop
//   shifts the row of stack cells up one slot.
//   When the receiver stalls with a report waiting, byte_stall rises and
//   the block holds all state until the report drains.
//   Reset clears the stack count, quote and escape flags, the position
//   counter and the error flag; the first byte after reset is position 0.
//   After the verdict the block returns to that state for the next text.
// ----------------------------------------------------------------------------
module bracket_quote_validator #(
	parameter int unsigned STACK_DEPTH = bqv_pkg::STACK_DEPTH_DEF,
	parameter int unsigned POS_WIDTH   = bqv_pkg::POS_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// byte channel
	input  logic                            byte_valid,
	output logic                            byte_stall,
	input  logic [bqv_pkg::CHAR_W-1:0]      text_byte,
	input  logic                            end_of_text,
	// report channel
	output logic                            report_valid,
	input  logic                            report_stall,
	output logic [bqv_pkg::RKIND_W-1:0]     report_kind,
	output logic [bqv_pkg::CHAR_W-1:0]      bracket_char,
	output logic [bqv_pkg::OUTPOS_W-1:0]    char_position,
	output logic                            text_valid,
	output logic                            run_last
);
	import bqv_pkg::*;

	// Run state
	state_t               state_q, state_d;
	logic                 sq_q, dq_q, bs_q, err_q;
	logic [POS_WIDTH-1:0] pos_q;

	// Report register
	logic                 rvalid_q;
	report_t              rep_q, rep_d;
	logic                 rep_load;

	// Stack interface
	stack_op_t            stk_op;
	logic                 stk_clear;
	br_kind_t             top_kind;
	logic [POS_WIDTH-1:0] top_pos;
	logic                 stk_empty, stk_full;

	// Byte decode
	logic                 accept, out_free;
	logic                 is_sq, is_dq, is_bs, sq_hit, dq_hit, br_active;
	br_dec_t              odec, cdec;
	logic                 ovf, mism, push_run, pop_run;
	logic                 sq_next, dq_next;

	// Flush selection
	logic                 fl_bracket, fl_sq, fl_dq, fl_verdict;

	logic [OUTPOS_W-1:0]  pos_out, top_pos_out;

	// Fit the internal position width to the 16-bit report field.
	if (POS_WIDTH >= OUTPOS_W) begin : g_pos_trunc
		assign pos_out     = pos_q[OUTPOS_W-1:0];
		assign top_pos_out = top_pos[OUTPOS_W-1:0];
	end else begin : g_pos_ext
		assign pos_out     = {{(OUTPOS_W-POS_WIDTH){1'b0}}, pos_q};
		assign top_pos_out = {{(OUTPOS_W-POS_WIDTH){1'b0}}, top_pos};
	end

	// The report register frees up when empty or when its beat goes out.
	assign out_free   = !rvalid_q || !report_stall;
	assign byte_stall = (state_q == ST_FLUSH) || (rvalid_q && report_stall);
	assign accept     = byte_valid && !byte_stall;

	// Quote tracking: a quote of the other kind inside a region is text,
	// and an odd backslash run before a quote escapes it.
	assign is_sq     = (text_byte == CH_SQUOTE);
	assign is_dq     = (text_byte == CH_DQUOTE);
	assign is_bs     = (text_byte == CH_BSLASH);
	assign sq_hit    = is_sq && !dq_q;
	assign dq_hit    = is_dq && !sq_q;
	assign sq_next   = sq_q ^ (sq_hit && !bs_q);
	assign dq_next   = dq_q ^ (dq_hit && !bs_q);
	assign br_active = !sq_q && !dq_q && !is_sq && !is_dq;

	// Brackets only count outside quotes.
	assign odec     = open_dec(text_byte);
	assign cdec     = close_dec(text_byte);
	assign ovf      = br_active && odec.hit && stk_full;
	assign push_run = br_active && odec.hit && !stk_full;
	assign mism     = br_active && cdec.hit && (stk_empty || top_kind != cdec.kind);
	assign pop_run  = br_active && cdec.hit && !mism;

	// Flush order: open brackets top down, then single, double, verdict.
	assign fl_bracket = !stk_empty;
	assign fl_sq      = stk_empty && sq_q;
	assign fl_dq      = stk_empty && !sq_q && dq_q;
	assign fl_verdict = stk_empty && !sq_q && !dq_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN: begin
				if (accept && end_of_text) state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (out_free && fl_verdict) state_d = ST_RUN;
			end
			default: state_d = ST_RUN;
		endcase
	end

	// Outputs of the sequencer: stack op and the report to load
	always_comb begin
		stk_op    = OP_HOLD;
		stk_clear = 1'b0;
		rep_load  = 1'b0;
		rep_d     = '{kind: RK_VERDICT, chr: CH_NONE, pos: '0, ok: 1'b0, last: 1'b0};
		unique case (state_q)
			ST_RUN: begin
				if (accept) begin
					if (push_run) stk_op = OP_PUSH;
					else if (pop_run) stk_op = OP_POP;
					if (ovf || mism) begin
						rep_load   = 1'b1;
						rep_d.kind = ovf ? RK_OVERFLOW : RK_UNMATCHED;
						rep_d.chr  = text_byte;
						rep_d.pos  = pos_out;
						rep_d.last = !end_of_text;
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					rep_load = 1'b1;
					if (fl_bracket) begin
						stk_op     = OP_POP;
						rep_d.kind = RK_UNCLOSED;
						rep_d.chr  = open_char(top_kind);
						rep_d.pos  = top_pos_out;
					end else if (fl_sq) begin
						rep_d.kind = RK_SQUOTE;
					end else if (fl_dq) begin
						rep_d.kind = RK_DQUOTE;
					end else begin
						stk_clear  = 1'b1;
						rep_d.kind = RK_VERDICT;
						rep_d.ok   = !err_q;
						rep_d.last = 1'b1;
					end
				end
			end
			default: begin
				stk_op = OP_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance per-text state on each beat; drop it all after the verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q  <= 1'b0;
			dq_q  <= 1'b0;
			bs_q  <= 1'b0;
			err_q <= 1'b0;
			pos_q <= '0;
		end else if (accept) begin
			sq_q  <= sq_next;
			dq_q  <= dq_next;
			bs_q  <= is_bs ? !bs_q : 1'b0;
			err_q <= err_q || ovf || mism;
			if (pos_q != {POS_WIDTH{1'b1}}) pos_q <= pos_q + POS_WIDTH'(1);
		end else if (state_q == ST_FLUSH && out_free) begin
			if (fl_verdict) begin
				sq_q  <= 1'b0;
				dq_q  <= 1'b0;
				bs_q  <= 1'b0;
				err_q <= 1'b0;
				pos_q <= '0;
			end else begin
				err_q <= 1'b1;
				if (fl_sq) sq_q <= 1'b0;
				if (fl_dq) dq_q <= 1'b0;
			end
		end
	end

	// Report register: hold while stalled, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else if (rep_load) begin
			rvalid_q <= 1'b1;
		end else if (!report_stall) begin
			rvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rep_load) rep_q <= rep_d;
	end

	bqv_stack #(
		.STACK_DEPTH(STACK_DEPTH),
		.POS_WIDTH  (POS_WIDTH)
	) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (stk_op),
		.clear    (stk_clear),
		.push_kind(odec.kind),
		.push_pos (pos_q),
		.top_kind (top_kind),
		.top_pos  (top_pos),
		.empty    (stk_empty),
		.full     (stk_full)
	);

	assign report_valid  = rvalid_q;
	assign report_kind   = rep_q.kind;
	assign bracket_char  = rep_q.chr;
	assign char_position = rep_q.pos;
	assign text_valid    = rep_q.ok;
	assign run_last      = rep_q.last;

endmodule

@@ test/bracket_quote_validator_tb.sv @@
// ----------------------------------------------------------------------------
// bracket_quote_validator_tb
// Self-checking bench for the streaming bracket and quote checker: texts go
// in one byte per beat, a behavioral predictor of the bracket stack, quote
// regions and escapes forms the expected reports, and every report beat is
// checked field by field against the oldest one awaited.
// ----------------------------------------------------------------------------
module bracket_quote_validator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bqv_pkg::*;

	localparam int          DEPTH          = STACK_DEPTH_DEF;
	localparam int unsigned POS_SAT        = int'((64'd1 << POS_WIDTH_DEF) - 64'd1);
	localparam int          HOLD_CYCLES    = 200;  // long receiver hold-off
	localparam int          WATCHDOG_LIMIT = 1000; // cycles with no beat at all
	localparam int          TAIL_CYCLES    = 100;  // settle time after the last report

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              eot;
	} text_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                byte_valid = 1'b0;
	logic                byte_stall;
	logic [CHAR_W-1:0]   text_byte = '0;
	logic                end_of_text = 1'b0;
	logic                report_valid;
	logic                report_stall = 1'b0;
	logic [RKIND_W-1:0]  report_kind;
	logic [CHAR_W-1:0]   bracket_char;
	logic [OUTPOS_W-1:0] char_position;
	logic                text_valid;
	logic                run_last;

	bracket_quote_validator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report_kind  (report_kind),
		.bracket_char (bracket_char),
		.char_position(char_position),
		.text_valid   (text_valid),
		.run_last     (run_last)
	);

	// Bytes waiting to be driven, and reports the predictor says must come.
	text_beat_t byte_backlog[$];
	report_t    awaited_reports[$];

	// Idle knobs, set per phase by the stimulus process.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;

	bit failed = 1'b0;

	// ------------------------------------------------------------------------
	// Predictor state: a private copy of what the block tracks per text.
	// ------------------------------------------------------------------------
	br_kind_t          nest_kind [DEPTH];
	logic [CHAR_W-1:0] nest_char [DEPTH];
	logic [15:0]       nest_pos  [DEPTH];
	int                nest_depth      = 0;
	bit                in_single       = 1'b0;
	bit                in_double       = 1'b0;
	bit                odd_backslashes = 1'b0;
	int unsigned       next_pos        = 0;
	bit                text_has_error  = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// Sort a byte into opening or closing bracket of some kind; zero if neither.
	function automatic bit bracket_role(input logic [CHAR_W-1:0] ch, output br_kind_t bk,
			output bit closes);
		bracket_role = 1'b1;
		closes = 1'b0;
		bk = BK_PAREN;
		case (ch)
			CH_LPAREN: bk = BK_PAREN;
			CH_LBRACK: bk = BK_BRACK;
			CH_LBRACE: bk = BK_BRACE;
			CH_LANGLE: bk = BK_ANGLE;
			CH_RPAREN: begin bk = BK_PAREN; closes = 1'b1; end
			CH_RBRACK: begin bk = BK_BRACK; closes = 1'b1; end
			CH_RBRACE: begin bk = BK_BRACE; closes = 1'b1; end
			CH_RANGLE: begin bk = BK_ANGLE; closes = 1'b1; end
			default:   bracket_role = 1'b0;
		endcase
	endfunction

	function automatic report_t make_report(input report_kind_t kind,
			input logic [CHAR_W-1:0] ch, input logic [15:0] pos, input logic ok);
		report_t r;
		r.kind = kind;
		r.chr  = ch;
		r.pos  = pos;
		r.ok   = ok;
		r.last = 1'b0;
		return r;
	endfunction

	// Advance the predictor by one accepted byte and queue the reports it causes.
	task automatic predict_reports(input logic [CHAR_W-1:0] ch, input logic eot);
		report_t     found[$];
		br_kind_t    bk;
		bit          closes;
		logic [15:0] here;
		here = next_pos[15:0];
		// A quote toggles its region unless an odd backslash run escapes it;
		// the other quote kind inside an open region is plain text.
		if (ch == CH_SQUOTE && !in_double) begin
			if (!odd_backslashes)
				in_single = !in_single;
		end else if (ch == CH_DQUOTE && !in_single) begin
			if (!odd_backslashes)
				in_double = !in_double;
		end else if (!in_single && !in_double && bracket_role(ch, bk, closes)) begin
			if (!closes) begin
				if (nest_depth < DEPTH) begin
					nest_kind[nest_depth] = bk;
					nest_char[nest_depth] = ch;
					nest_pos[nest_depth]  = here;
					nest_depth++;
				end else begin
					// full stack: drop the opener and flag it
					found = {found, make_report(RK_OVERFLOW, ch, here, 1'b0)};
					text_has_error = 1'b1;
				end
			end else if (nest_depth == 0 || nest_kind[nest_depth-1] != bk) begin
				// mismatch leaves the stack as it is
				found = {found, make_report(RK_UNMATCHED, ch, here, 1'b0)};
				text_has_error = 1'b1;
			end else begin
				nest_depth--;
			end
		end
		odd_backslashes = (ch == CH_BSLASH) ? !odd_backslashes : 1'b0;
		if (next_pos < POS_SAT)
			next_pos++;
		if (eot) begin
			// Unwind open brackets top first, then open quotes, then the verdict.
			while (nest_depth > 0) begin
				nest_depth--;
				found = {found, make_report(RK_UNCLOSED, nest_char[nest_depth],
					nest_pos[nest_depth], 1'b0)};
				text_has_error = 1'b1;
			end
			if (in_single) begin
				found = {found, make_report(RK_SQUOTE, CH_NONE, '0, 1'b0)};
				text_has_error = 1'b1;
			end
			if (in_double) begin
				found = {found, make_report(RK_DQUOTE, CH_NONE, '0, 1'b0)};
				text_has_error = 1'b1;
			end
			found = {found, make_report(RK_VERDICT, CH_NONE, '0, !text_has_error)};
			in_single       = 1'b0;
			in_double       = 1'b0;
			odd_backslashes = 1'b0;
			next_pos        = 0;
			text_has_error  = 1'b0;
		end
		if (found.size() > 0)
			found[found.size()-1].last = 1'b1;
		foreach (found[i])
			awaited_reports = {awaited_reports, found[i]};
	endtask

	function automatic void check_field(input string field, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", field, want, got);
			failed = 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Driver: hold a beat until it is taken, then offer the next one or idle.
	// The predictor runs at the edge where the beat is accepted.
	// ------------------------------------------------------------------------
	text_beat_t next_beat;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid  <= 1'b0;
			text_byte   <= '0;
			end_of_text <= 1'b0;
		end else begin
			if (byte_valid && !byte_stall)
				predict_reports(text_byte, end_of_text);
			if (!byte_valid || !byte_stall) begin
				if (byte_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_beat = byte_backlog.pop_front();
					byte_valid  <= 1'b1;
					text_byte   <= next_beat.ch;
					end_of_text <= next_beat.eot;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Receiver stall: random per phase, or a long hold-off on request so the
	// block backs up and stalls the byte channel.
	// ------------------------------------------------------------------------
	int hold_left   = 0;
	int hold_served = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			report_stall <= 1'b1;
		end else if (hold_served != hold_requests) begin
			hold_served++;
			hold_left = HOLD_CYCLES - 1;
			report_stall <= 1'b1;
		end else begin
			report_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Monitor and watchdog.
	// ------------------------------------------------------------------------
	report_t want_report;
	int      quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (report_valid && !report_stall) begin
				if (awaited_reports.size() == 0) begin
					$error("report beat with none awaited: report_kind %0d, bracket_char %0h",
						report_kind, bracket_char);
					failed = 1'b1;
				end else begin
					want_report = awaited_reports.pop_front();
					check_field("report_kind", 16'(want_report.kind), 16'(report_kind));
					check_field("bracket_char", 16'(want_report.chr), 16'(bracket_char));
					check_field("char_position", want_report.pos, char_position);
					check_field("text_valid", 16'(want_report.ok), 16'(text_valid));
					check_field("run_last", 16'(want_report.last), 16'(run_last));
				end
			end
			if ((byte_valid && !byte_stall) || (report_valid && !report_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic queue_text(input logic [CHAR_W-1:0] txt[$]);
		foreach (txt[i])
			byte_backlog = {byte_backlog,
				text_beat_t'{ch: txt[i], eot: (i == txt.size() - 1)}};
	endtask

	task automatic pick_pair(output logic [CHAR_W-1:0] opener, output logic [CHAR_W-1:0] closer);
		case (br_kind_t'($urandom_range(3)))
			BK_PAREN: begin opener = CH_LPAREN; closer = CH_RPAREN; end
			BK_BRACK: begin opener = CH_LBRACK; closer = CH_RBRACK; end
			BK_BRACE: begin opener = CH_LBRACE; closer = CH_RBRACE; end
			default:  begin opener = CH_LANGLE; closer = CH_RANGLE; end
		endcase
	endtask

	// Build one text: mostly nested brackets that close in order, quoted runs
	// with escapes, backslash runs, plus stray closers and raw noise bytes.
	task automatic queue_random_text(output int produced);
		logic [CHAR_W-1:0] txt[$];
		logic [CHAR_W-1:0] owed[$];
		logic [CHAR_W-1:0] op, cl, q;
		int target;
		target = ($urandom_range(7) == 0) ? $urandom_range(48, 20) : $urandom_range(14, 1);
		// now and then run the stack up to and past its depth
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(DEPTH + 4, DEPTH - 2)) begin
				pick_pair(op, cl);
				txt = {txt, op};
				owed = {owed, cl};
			end
		end
		while (txt.size() < target) begin
			case ($urandom_range(9))
				0, 1, 2: begin
					pick_pair(op, cl);
					txt = {txt, op};
					owed = {owed, cl};
				end
				3, 4: begin
					if (owed.size() > 0) begin
						txt = {txt, owed[owed.size() - 1]};
						owed.delete(owed.size() - 1);
					end else begin
						txt = {txt, 8'($urandom_range(255))};
					end
				end
				5: begin
					q = ($urandom_range(1) != 0) ? CH_SQUOTE : CH_DQUOTE;
					txt = {txt, q};
					repeat ($urandom_range(5)) begin
						case ($urandom_range(3))
							0: begin
								pick_pair(op, cl);
								txt = {txt, (($urandom_range(1) != 0) ? op : cl)};
							end
							1: begin
								// escaped quote stays inside the region
								txt = {txt, CH_BSLASH};
								txt = {txt, q};
							end
							2: txt = {txt, ((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE)};
							default: txt = {txt, 8'($urandom_range(8'h7A, 8'h61))};
						endcase
					end
					if ($urandom_range(5) != 0)
						txt = {txt, q};
				end
				6: begin
					repeat ($urandom_range(4, 1))
						txt = {txt, CH_BSLASH};
					if ($urandom_range(1) != 0)
						txt = {txt, (($urandom_range(1) != 0) ? CH_SQUOTE : CH_DQUOTE)};
				end
				7: begin
					pick_pair(op, cl);
					txt = {txt, cl};
				end
				default: txt = {txt, 8'($urandom_range(255))};
			endcase
		end
		// most texts close what they opened; the rest leave brackets hanging
		if ($urandom_range(4) != 0) begin
			while (owed.size() > 0) begin
				txt = {txt, owed[owed.size() - 1]};
				owed.delete(owed.size() - 1);
			end
		end
		queue_text(txt);
		produced = txt.size();
	endtask

	// Wait until every byte is taken and every awaited report has come.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (byte_backlog.size() > 0 || byte_valid || awaited_reports.size() > 0);
	endtask

	task automatic run_phase(input int send_pct, input int stall_pct, input int budget,
			input bit squeeze);
		int produced;
		int total;
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
		total = 0;
		if (squeeze)
			hold_requests++;
		while (total < budget) begin
			queue_random_text(produced);
			total += produced;
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin
		logic [CHAR_W-1:0] txt[$];
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Balanced nest of every bracket kind between the byte extremes.
		txt = {8'h00, CH_LPAREN, CH_LBRACK, CH_LBRACE, CH_LANGLE,
			CH_RANGLE, CH_RBRACE, CH_RBRACK, CH_RPAREN, 8'hFF};
		queue_text(txt);
		// Closer on an empty stack, a mismatched closer that leaves the '('
		// in place, a bracket and an escaped quote inside a double-quote
		// region, a single quote treated as text there, then an even
		// backslash run that leaves the final single quote open.
		txt = {CH_RPAREN, CH_LPAREN, CH_RBRACK, CH_DQUOTE, CH_LPAREN, CH_BSLASH,
			CH_DQUOTE, CH_SQUOTE, CH_DQUOTE, CH_BSLASH, CH_BSLASH, CH_SQUOTE};
		queue_text(txt);
		wait_drained();

		// Random texts under each idle pattern.
		run_phase(0, 0, 30, 1'b0);
		run_phase(84, 0, 30, 1'b0);
		run_phase(0, 84, 30, 1'b0);
		run_phase(21, 21, 30, 1'b0);
		// Hold the receiver off while the sender keeps offering bytes.
		run_phase(0, 0, 30, 1'b1);

		// Fill the stack and overflow it, then close the top, open a new
		// bracket, hit it with a wrong closer and leave a double quote open.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		txt = {};
		repeat (DEPTH + 1)
			txt = {txt, CH_LANGLE};
		txt = {txt, CH_RANGLE};
		txt = {txt, CH_LPAREN};
		txt = {txt, CH_RBRACK};
		txt = {txt, CH_DQUOTE};
		queue_text(txt);
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (awaited_reports.size() > 0) begin
			$error("%0d awaited reports never arrived", awaited_reports.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
